// ===== sv/dxtd_pkg.sv =====
package dxtd_pkg;

  // Alpha source selected by the format register
  typedef enum logic [1:0] {
    MODE_DXT1_OPAQUE = 2'd0,
    MODE_DXT1_ALPHA  = 2'd1,
    MODE_DXT3        = 2'd2,
    MODE_DXT5        = 2'd3
  } mode_t;

  // Reciprocal multipliers for the palette mixes (exact over the sum ranges used)
  localparam logic [9:0]  RECIP3 = 10'd683;   // x/3 for x < 2048
  localparam int          SHIFT3 = 11;
  localparam logic [11:0] RECIP7 = 12'd2341;  // x/7 for x < 5461
  localparam int          SHIFT7 = 14;
  localparam logic [10:0] RECIP5 = 11'd1639;  // x/5 for x < 2730
  localparam int          SHIFT5 = 13;

  localparam logic [7:0] ALPHA_OPAQUE      = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR       = 8'h00;
  localparam logic [2:0] ALPHA_WEIGHT_MAX5 = 3'd4;
  localparam logic [2:0] ALPHA_WEIGHT_ONE  = 3'd6;
  localparam logic [1:0] COLOR_IDX_CLEAR   = 2'd3;
  localparam logic [3:0] LAST_TEXEL        = 4'd15;

  // Four 8-bit palette entries of one channel
  typedef logic [3:0][7:0] pal4_t;

  // Per-block fields that travel beside the palette lanes
  typedef struct packed {
    mode_t       mode;
    logic        four_color;
    logic [31:0] color_idx;
    logic [63:0] alpha_bits;
  } side_t;

  // Everything the texel stage needs for one block
  typedef struct packed {
    side_t           side;
    pal4_t           red;
    pal4_t           green;
    pal4_t           blue;
    logic [7:0][7:0] alpha_pal;
  } block_pal_t;

  // One decoded texel
  typedef struct packed {
    logic [3:0]  texel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] packed_rgb565;
    logic        last_texel;
  } texel_t;

endpackage

// ===== sv/dxt_block_texel_decoder_unit.sv =====
// A block request passes through stages p1, p2 and p3 into the emit register; each
// texel then passes through the output register.
// Throughput: one texel per cycle while the output is not stalled, set by the single
// output port; three palette stages buffer the next blocks meanwhile.
// Reset (synchronous, rst high) clears all valid flags and sets the format to
// DXT1 opaque; no memory is cleared.
module dxt_block_texel_decoder_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_data,     // format_mode
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,      // color_block [63:0], alpha_block [127:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,      // texel_index [3:0], red [11:4], green [19:12],
                                     // blue [27:20], alpha [35:28],
                                     // packed_rgb565 [51:36], zero [55:52]
  output logic         m_tlast       // last_texel
);
  import dxtd_pkg::*;

  mode_t           mode;
  logic            p1_valid;
  logic [63:0]     p1_color;
  logic [63:0]     p1_alpha;
  mode_t           p1_mode;
  logic            p2_valid;
  side_t           p2_side;
  logic            p3_valid;
  side_t           p3_side;
  logic            em_valid;
  logic [3:0]      em_cnt;
  block_pal_t      em_pal;
  block_pal_t      p3_pal;
  texel_t          out_texel;
  texel_t          texel_next;

  logic            out_free;
  logic            em_fire;
  logic            em_done;
  logic            p3_ready;
  logic            p3_move;
  logic            p2_ready;
  logic            p2_move;
  logic            p1_ready;
  logic            p1_move;
  logic            s_fire;

  logic [15:0]     c0;
  logic [15:0]     c1;
  logic            four_color;
  pal4_t           red_pal;
  pal4_t           green_pal;
  pal4_t           blue_pal;
  logic [5:0][7:0] alpha_mid;

  // Flow control from the output register back to the input
  assign out_free = !m_tvalid || m_tready;
  assign em_fire  = em_valid && out_free;
  assign em_done  = em_fire && (em_cnt == LAST_TEXEL);
  assign p3_ready = !em_valid || em_done;
  assign p3_move  = p3_valid && p3_ready;
  assign p2_ready = !p3_valid || p3_ready;
  assign p2_move  = p2_valid && p2_ready;
  assign p1_ready = !p2_valid || p2_ready;
  assign p1_move  = p1_valid && p1_ready;
  assign s_tready = !p1_valid || p1_ready;
  assign s_fire   = s_tvalid && s_tready;

  // Hold the format register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DXT1_OPAQUE;
    end else if (cfg_we) begin
      mode <= mode_t'(cfg_data);
    end
  end

  // Valid flags and texel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      em_valid <= 1'b0;
      em_cnt   <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      p1_valid <= s_fire || (p1_valid && !p1_move);
      p2_valid <= p1_move || (p2_valid && !p2_move);
      p3_valid <= p2_move || (p3_valid && !p3_move);
      em_valid <= p3_move || (em_valid && !em_done);
      m_tvalid <= em_fire || (m_tvalid && !m_tready);
      if (p3_move) begin
        em_cnt <= 4'd0;
      end else if (em_fire) begin
        em_cnt <= em_cnt + 4'd1;
      end
    end
  end

  // Capture the block request
  always_ff @(posedge clk) begin
    if (s_fire) begin
      p1_color <= s_tdata[63:0];
      p1_alpha <= s_tdata[127:64];
      p1_mode  <= mode;
    end
  end

  assign c0 = p1_color[15:0];
  assign c1 = p1_color[31:16];
  assign four_color = (c0 > c1) || (p1_mode == MODE_DXT3) || (p1_mode == MODE_DXT5);

  // Carry the per-block fields beside the lanes
  always_ff @(posedge clk) begin
    if (p1_move) begin
      p2_side.mode       <= p1_mode;
      p2_side.four_color <= four_color;
      p2_side.color_idx  <= p1_color[63:32];
      p2_side.alpha_bits <= p1_alpha;
    end
    if (p2_move) begin
      p3_side <= p2_side;
    end
  end

  // One lane per color channel
  dxtd_color_lane u_red (
    .clk        (clk),
    .adv_a      (p1_move),
    .adv_b      (p2_move),
    .e0         ({c0[15:11], c0[15:13]}),
    .e1         ({c1[15:11], c1[15:13]}),
    .four_color (four_color),
    .entries    (red_pal)
  );

  dxtd_color_lane u_green (
    .clk        (clk),
    .adv_a      (p1_move),
    .adv_b      (p2_move),
    .e0         ({c0[10:5], c0[10:9]}),
    .e1         ({c1[10:5], c1[10:9]}),
    .four_color (four_color),
    .entries    (green_pal)
  );

  dxtd_color_lane u_blue (
    .clk        (clk),
    .adv_a      (p1_move),
    .adv_b      (p2_move),
    .e0         ({c0[4:0], c0[4:2]}),
    .e1         ({c1[4:0], c1[4:2]}),
    .four_color (four_color),
    .entries    (blue_pal)
  );

  // One lane per interpolated alpha entry
  for (genvar g = 0; g < 6; g++) begin : g_alpha
    dxtd_alpha_lane u_alpha (
      .clk    (clk),
      .adv_a  (p1_move),
      .adv_b  (p2_move),
      .a0     (p1_alpha[7:0]),
      .a1     (p1_alpha[15:8]),
      .gt     (p1_alpha[7:0] > p1_alpha[15:8]),
      .weight (3'(g + 1)),
      .entry  (alpha_mid[g])
    );
  end

  // Gather lane results for the texel stage
  always_comb begin
    p3_pal.side         = p3_side;
    p3_pal.red          = red_pal;
    p3_pal.green        = green_pal;
    p3_pal.blue         = blue_pal;
    p3_pal.alpha_pal[0] = p3_side.alpha_bits[7:0];
    p3_pal.alpha_pal[1] = p3_side.alpha_bits[15:8];
    for (int k = 0; k < 6; k++) begin
      p3_pal.alpha_pal[k + 2] = alpha_mid[k];
    end
  end

  // Hold the palette of the block being emitted
  always_ff @(posedge clk) begin
    if (p3_move) begin
      em_pal <= p3_pal;
    end
  end

  dxtd_texel_merge u_merge (
    .pal   (em_pal),
    .cnt   (em_cnt),
    .texel (texel_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (em_fire) begin
      out_texel <= texel_next;
    end
  end

  assign m_tdata = {4'b0000, out_texel.packed_rgb565, out_texel.alpha, out_texel.blue,
                    out_texel.green, out_texel.red, out_texel.texel_index};
  assign m_tlast = out_texel.last_texel;

  // Texels of a block leave in order without gaps
  a_texel_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && out_texel.texel_index == $past(out_texel.texel_index) + 4'd1)
    else $error("texel sequence broken");

  // The emitting palette stays put until its last texel leaves
  a_pal_hold: assert property (@(posedge clk) disable iff (rst)
    em_valid && !em_done |=> em_pal == $past(em_pal))
    else $error("palette changed mid-block");

  // A stalled first stage keeps its block
  a_p1_hold: assert property (@(posedge clk) disable iff (rst)
    p1_valid && !p1_move |=> p1_valid && p1_color == $past(p1_color)
                            && p1_alpha == $past(p1_alpha))
    else $error("input stage lost its block");

endmodule

// ===== sv/dxtd_color_lane.sv =====
module dxtd_color_lane (
  input  logic               clk,
  input  logic               adv_a,
  input  logic               adv_b,
  input  logic [7:0]         e0,
  input  logic [7:0]         e1,
  input  logic               four_color,
  output dxtd_pkg::pal4_t    entries
);
  import dxtd_pkg::*;

  logic [7:0]  e0_a;
  logic [7:0]  e1_a;
  logic [9:0]  sum2_a;
  logic [9:0]  sum3_a;
  logic [7:0]  half_a;
  logic        four_a;
  logic [8:0]  pair_sum;
  logic [19:0] prod2;
  logic [19:0] prod3;

  assign pair_sum = {1'b0, e0} + {1'b0, e1};

  // Form the weighted sums of the two endpoints
  always_ff @(posedge clk) begin
    if (adv_a) begin
      e0_a   <= e0;
      e1_a   <= e1;
      sum2_a <= {1'b0, e0, 1'b0} + {2'b00, e1};
      sum3_a <= {2'b00, e0} + {1'b0, e1, 1'b0};
      half_a <= pair_sum[8:1];
      four_a <= four_color;
    end
  end

  assign prod2 = 20'(sum2_a) * 20'(RECIP3);
  assign prod3 = 20'(sum3_a) * 20'(RECIP3);

  // Divide by three and pick the palette form
  always_ff @(posedge clk) begin
    if (adv_b) begin
      entries[0] <= e0_a;
      entries[1] <= e1_a;
      entries[2] <= four_a ? prod2[SHIFT3 +: 8] : half_a;
      entries[3] <= four_a ? prod3[SHIFT3 +: 8] : 8'd0;
    end
  end

endmodule

// ===== sv/dxtd_alpha_lane.sv =====
module dxtd_alpha_lane (
  input  logic       clk,
  input  logic       adv_a,
  input  logic       adv_b,
  input  logic [7:0] a0,
  input  logic [7:0] a1,
  input  logic       gt,
  input  logic [2:0] weight,
  output logic [7:0] entry
);
  import dxtd_pkg::*;

  logic [2:0]  w7;
  logic [2:0]  w5;
  logic        use_five;
  logic [10:0] s7_a;
  logic [10:0] s5_a;
  logic        gt_a;
  logic        five_a;
  logic        one_a;
  logic [22:0] q7;
  logic [21:0] q5;

  assign use_five = (weight <= ALPHA_WEIGHT_MAX5);
  assign w7 = 3'd7 - weight;
  assign w5 = use_five ? 3'd5 - weight : 3'd0;

  // Form both weighted sums of the alpha endpoints
  always_ff @(posedge clk) begin
    if (adv_a) begin
      s7_a   <= 11'(w7) * 11'(a0) + 11'(weight) * 11'(a1);
      s5_a   <= 11'(w5) * 11'(a0) + 11'(weight) * 11'(a1);
      gt_a   <= gt;
      five_a <= use_five;
      one_a  <= (weight == ALPHA_WEIGHT_ONE);
    end
  end

  assign q7 = 23'(s7_a) * 23'(RECIP7);
  assign q5 = 22'(s5_a) * 22'(RECIP5);

  // Divide and select; the six-step palette ends in clear and opaque
  always_ff @(posedge clk) begin
    if (adv_b) begin
      if (gt_a) begin
        entry <= q7[SHIFT7 +: 8];
      end else if (five_a) begin
        entry <= q5[SHIFT5 +: 8];
      end else begin
        entry <= one_a ? ALPHA_OPAQUE : ALPHA_CLEAR;
      end
    end
  end

endmodule

// ===== sv/dxtd_texel_merge.sv =====
module dxtd_texel_merge (
  input  dxtd_pkg::block_pal_t pal,
  input  logic [3:0]           cnt,
  output dxtd_pkg::texel_t     texel
);
  import dxtd_pkg::*;

  logic [1:0] ci;
  logic [3:0] nib;
  logic [2:0] ai;
  logic [5:0] ai_pos;

  assign ci     = pal.side.color_idx[{cnt, 1'b0} +: 2];
  assign nib    = pal.side.alpha_bits[{cnt, 2'b00} +: 4];
  assign ai_pos = 6'd16 + 6'(cnt) * 6'd3;
  assign ai     = pal.side.alpha_bits[ai_pos +: 3];

  // Combine color lanes and alpha source into one texel
  always_comb begin
    texel.texel_index = cnt;
    texel.red         = pal.red[ci];
    texel.green       = pal.green[ci];
    texel.blue        = pal.blue[ci];
    texel.last_texel  = (cnt == LAST_TEXEL);
    unique case (pal.side.mode)
      MODE_DXT3: texel.alpha = {nib, nib};
      MODE_DXT5: texel.alpha = pal.alpha_pal[ai];
      MODE_DXT1_OPAQUE, MODE_DXT1_ALPHA: begin
        texel.alpha = (!pal.side.four_color && ci == COLOR_IDX_CLEAR) ? ALPHA_CLEAR
                                                                     : ALPHA_OPAQUE;
      end
    endcase
    if (pal.side.mode == MODE_DXT1_OPAQUE) begin
      texel.packed_rgb565 = {texel.red[7:3], texel.green[7:2], texel.blue[7:3]};
    end else begin
      texel.packed_rgb565 = 16'd0;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import dxtd_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_data = 2'd0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;      // color_block [63:0], alpha_block [127:64]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;           // texel_index [3:0], red [11:4], green [19:12],
                                   // blue [27:20], alpha [35:28],
                                   // packed_rgb565 [51:36], zero [55:52]
  logic         m_tlast;           // last_texel

  // Local copy of the format register and the texels still owed by the block
  mode_t  cur_format = MODE_DXT1_OPAQUE;
  texel_t pending_texels[$];
  texel_t want;
  bit     stalls_on = 1'b1;
  int     mismatch_count = 0;
  int     blocks_sent = 0;
  int     texels_seen = 0;

  dxt_block_texel_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Expand one block into its sixteen texels under the current format
  function automatic void decode_block(input logic [63:0] color, input logic [63:0] alpha);
    logic [15:0] c0, c1;
    logic [7:0]  ep [2][3];
    logic [7:0]  pal [4][4];   // entry, then red/green/blue/alpha
    logic [7:0]  apal [8];
    logic [7:0]  a0, a1;
    logic [1:0]  ci;
    logic [3:0]  nib;
    texel_t      t;
    c0 = color[15:0];
    c1 = color[31:16];
    ep[0][0] = {c0[15:11], c0[15:13]};
    ep[0][1] = {c0[10:5], c0[10:9]};
    ep[0][2] = {c0[4:0], c0[4:2]};
    ep[1][0] = {c1[15:11], c1[15:13]};
    ep[1][1] = {c1[10:5], c1[10:9]};
    ep[1][2] = {c1[4:0], c1[4:2]};
    for (int ch = 0; ch < 3; ch++) begin
      pal[0][ch] = ep[0][ch];
      pal[1][ch] = ep[1][ch];
    end
    pal[0][3] = ALPHA_OPAQUE;
    pal[1][3] = ALPHA_OPAQUE;
    pal[2][3] = ALPHA_OPAQUE;
    // DXT3 and DXT5 always take the four-color palette
    if (c0 > c1 || cur_format == MODE_DXT3 || cur_format == MODE_DXT5) begin
      for (int ch = 0; ch < 3; ch++) begin
        pal[2][ch] = 8'((2 * ep[0][ch] + ep[1][ch]) / 3);
        pal[3][ch] = 8'((ep[0][ch] + 2 * ep[1][ch]) / 3);
      end
      pal[3][3] = ALPHA_OPAQUE;
    end else begin
      for (int ch = 0; ch < 3; ch++) begin
        pal[2][ch] = 8'((ep[0][ch] + ep[1][ch]) / 2);
        pal[3][ch] = 8'd0;
      end
      pal[3][3] = ALPHA_CLEAR;
    end
    // Eight-entry interpolated alpha palette
    a0 = alpha[7:0];
    a1 = alpha[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k < 7; k++)
        apal[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
    end else begin
      for (int k = 1; k < 5; k++)
        apal[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
      apal[6] = ALPHA_CLEAR;
      apal[7] = ALPHA_OPAQUE;
    end
    for (int i = 0; i < 16; i++) begin
      ci = color[32 + 2 * i +: 2];
      t.texel_index = 4'(i);
      t.red   = pal[ci][0];
      t.green = pal[ci][1];
      t.blue  = pal[ci][2];
      case (cur_format)
        MODE_DXT3: begin
          nib = alpha[4 * i +: 4];
          t.alpha = {nib, nib};
        end
        MODE_DXT5: t.alpha = apal[alpha[16 + 3 * i +: 3]];
        default:   t.alpha = pal[ci][3];
      endcase
      t.packed_rgb565 = (cur_format == MODE_DXT1_OPAQUE) ?
                        {t.red[7:3], t.green[7:2], t.blue[7:3]} : 16'h0000;
      t.last_texel = (i == 15);
      pending_texels.push_back(t);
    end
  endfunction

  task automatic check_field(input string what, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
    end
  endtask

  // Stall the texel output at random while stalls are enabled
  always @(posedge clk)
    m_tready <= !stalls_on || ($urandom_range(0, 99) >= 10);

  // Compare each accepted texel against the oldest pending one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      texels_seen++;
      if (pending_texels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected texel, expected none, got %h", $time, m_tdata);
      end else begin
        want = pending_texels.pop_front();
        check_field("texel_index", 16'(want.texel_index), 16'(m_tdata[3:0]));
        check_field("red", 16'(want.red), 16'(m_tdata[11:4]));
        check_field("green", 16'(want.green), 16'(m_tdata[19:12]));
        check_field("blue", 16'(want.blue), 16'(m_tdata[27:20]));
        check_field("alpha", 16'(want.alpha), 16'(m_tdata[35:28]));
        check_field("packed_rgb565", want.packed_rgb565, m_tdata[51:36]);
        check_field("last_texel", 16'(want.last_texel), 16'(m_tlast));
      end
    end
  end

  // Present one block request, hold until accepted, then maybe idle
  task automatic run_block(input logic [63:0] color, input logic [63:0] alpha);
    s_tvalid <= 1'b1;
    s_tdata  <= {alpha, color};
    do @(posedge clk); while (!s_tready);
    decode_block(color, alpha);
    blocks_sent++;
    if (stalls_on && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop the request and wait until every pending texel has come out
  task automatic drain_texels();
    s_tvalid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_format(input mode_t m);
    drain_texels();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_format = m;
  endtask

  // Random endpoints, biased toward each palette order and equal endpoints
  function automatic logic [63:0] pick_color();
    logic [15:0] p, q;
    p = 16'($urandom);
    q = 16'($urandom);
    case ($urandom_range(0, 3))
      0: return {32'($urandom), (p > q) ? q : p, (p > q) ? p : q};
      1: return {32'($urandom), (p > q) ? p : q, (p > q) ? q : p};
      2: return {32'($urandom), p, p};
      default: return {32'($urandom), q, p};
    endcase
  endfunction

  function automatic logic [63:0] pick_alpha();
    logic [63:0] v;
    v = {32'($urandom), 32'($urandom)};
    case ($urandom_range(0, 4))
      0: v[15:0] = {8'h00, 8'hFF};
      1: v[15:0] = {8'hFF, 8'h00};
      2: v[15:8] = v[7:0];
      default: ;
    endcase
    return v;
  endfunction

  // Reset default format: both palette orders, equal endpoints, field extremes
  task automatic test_dxt1_opaque();
    run_block({32'hE4E4E4E4, 16'h001F, 16'hF800}, 64'h0);
    run_block({32'h1B1B1B1B, 16'hFFFF, 16'h0000}, 64'hFFFFFFFFFFFFFFFF);
    run_block({32'hE4E4E4E4, 16'h7BEF, 16'h7BEF}, 64'h0);
    run_block(64'h0, 64'h0);
    run_block(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
    run_block({32'hFFFFFFFF, 16'h07E0, 16'hFFFF}, {$urandom, $urandom});
  endtask

  // DXT1 with alpha: transparent index 3 only when c0 <= c1
  task automatic test_dxt1_alpha();
    set_format(MODE_DXT1_ALPHA);
    run_block({32'hFFE4FF1B, 16'hF81F, 16'h07E0}, {$urandom, $urandom});
    run_block({32'hFFE4FF1B, 16'h07E0, 16'hF81F}, 64'hFFFFFFFFFFFFFFFF);
    run_block(64'hFFFFFFFFFFFFFFFF, 64'h0);
  endtask

  // DXT3: explicit nibbles, four-color palette even when c0 <= c1
  task automatic test_dxt3();
    set_format(MODE_DXT3);
    run_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'h0);
    run_block({32'hFFFFFFFF, 16'h8410, 16'h8410}, 64'hFFFFFFFFFFFFFFFF);
    run_block({32'h1B1B1B1B, 16'hF800, 16'h001F}, 64'hFEDCBA9876543210);
    run_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // DXT5: eight- and six-entry alpha palettes, equal endpoints, extremes
  task automatic test_dxt5();
    set_format(MODE_DXT5);
    run_block({32'hE4E4E4E4, 16'h001F, 16'hF800}, {24'hFAC688, 24'hFAC688, 8'h00, 8'hFF});
    run_block({32'hE4E4E4E4, 16'hF800, 16'h001F}, {24'hFAC688, 24'hFAC688, 8'hFF, 8'h00});
    run_block({$urandom, $urandom}, {24'hFAC688, 24'hFAC688, 8'h80, 8'h80});
    run_block(64'h0, 64'h0);
    run_block(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
  endtask

  // Random blocks in every format; one phase runs without any idling
  task automatic test_random_blocks();
    mode_t order [4] = '{MODE_DXT5, MODE_DXT1_OPAQUE, MODE_DXT3, MODE_DXT1_ALPHA};
    for (int ph = 0; ph < 4; ph++) begin
      set_format(order[ph]);
      stalls_on = (ph != 1);
      for (int n = 0; n < 28; n++) begin
        if (ph == 0 && n == 16)
          drain_texels();
        run_block(pick_color(), pick_alpha());
      end
    end
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_dxt1_opaque();
    test_dxt1_alpha();
    test_dxt3();
    test_dxt5();
    test_random_blocks();
    drain_texels();
    repeat (20) @(posedge clk);
    if (pending_texels.size() != 0) begin
      mismatch_count++;
      $display("%0t: texels missing, expected %0d more, got none", $time,
               pending_texels.size());
    end
    $display("Run covered %0d blocks (%0d texels) in all four formats, both palette orders,",
             blocks_sent, texels_seen);
    $display("equal endpoints, random sender gaps, receiver stalls and a mid-run drain.");
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
